/* hw/rtl/dvlc_pkg.sv */
// Package for the delta VLC byte decoder: phase type, constants, shifter control.
package dvlc_pkg;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FIRST,
        PH_SIGN,
        PH_RUN,
        PH_MAG,
        PH_DONE
    } phase_t;

    localparam int BYTE_BITS     = 8;
    localparam int COUNT_BITS    = 32;
    localparam int HDR_IDX_BITS  = 2;
    localparam int BIT_CNT_BITS  = 4;
    localparam int ACC_POS_BITS  = 3;
    localparam int MAG_EXTRA     = 3;

    localparam logic [HDR_IDX_BITS-1:0] HDR_LAST_IDX = 2'd3;

    // Control from the decoder to the byte shifter
    typedef struct packed {
        logic step;   // consume the current bit
        logic flush;  // drop the rest of the byte
    } shift_ctrl_t;

endpackage

/* hw/rtl/dvlc_bit_shifter.sv */
// Byte holding register that presents code bits MSB first, one per step.
module dvlc_bit_shifter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic [7:0]                 load_byte,
    input  dvlc_pkg::shift_ctrl_t      ctrl,
    output logic                       cur_bit,
    output logic [7:0]                 cur_byte,
    output logic                       empty
);
    import dvlc_pkg::*;

    logic [BYTE_BITS-1:0]    byte_reg;
    logic [BYTE_BITS-1:0]    byte_next;
    logic [BIT_CNT_BITS-1:0] left_reg;
    logic [BIT_CNT_BITS-1:0] left_next;

    // Load, shift or flush the held byte
    always_comb
    begin
        byte_next = byte_reg;
        left_next = left_reg;
        if (load)
        begin
            byte_next = load_byte;
            left_next = BIT_CNT_BITS'(BYTE_BITS);
        end
        else if (ctrl.flush)
        begin
            left_next = '0;
        end
        else if (ctrl.step)
        begin
            byte_next = {byte_reg[BYTE_BITS-2:0], 1'b0};
            left_next = left_reg - 1'b1;
        end
    end

    // Hold bit count under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign cur_bit  = byte_reg[BYTE_BITS-1];
    assign cur_byte = byte_reg;
    assign empty    = (left_reg == '0);

endmodule

/* hw/rtl/delta_vlc_byte_decoder.sv */
// Top level of the delta VLC byte decoder: bit-serial code parser and output register.
//
// The decoder takes one byte per transfer. The four header bytes (big-endian
// sample count) and the first raw sample are each loaded and then flushed whole.
// Every later byte is loaded and then walked one code bit per cycle; the bit
// walk is the limit, since each bit's meaning depends on the one before it.
// A byte can yield up to two samples; a sample waits in the output register,
// and the bit walk pauses only when a new sample is ready while the previous
// one is still stalled. After the last sample of the count (flagged by last),
// or after a zero count, the rest of the stream is dropped until reset.
module delta_vlc_byte_decoder #(
    parameter int RUN_COUNT_BITS = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] sample,
    output logic       last
);
    import dvlc_pkg::*;

    localparam int IDX_BITS = RUN_COUNT_BITS + 1;
    localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = '1;

    phase_t                    phase_reg, phase_next;
    logic [HDR_IDX_BITS-1:0]   hdr_idx_reg, hdr_idx_next;
    logic [COUNT_BITS-1:0]     cnt_reg, cnt_next;
    logic                      sign_reg, sign_next;
    logic [RUN_COUNT_BITS-1:0] run_reg, run_next;
    logic [IDX_BITS-1:0]       mag_idx_reg, mag_idx_next;
    logic [BYTE_BITS-1:0]      acc_reg, acc_next;
    logic [BYTE_BITS-1:0]      cur_reg, cur_next;
    logic                      out_valid_reg, out_valid_next;
    logic [BYTE_BITS-1:0]      sample_reg, sample_next;
    logic                      last_reg, last_next;

    shift_ctrl_t               ctrl;
    logic                      cur_bit;
    logic [BYTE_BITS-1:0]      cur_byte;
    logic                      empty;
    logic                      load;
    logic                      out_free;
    logic                      emit;
    logic [BYTE_BITS-1:0]      emit_sample;
    logic [COUNT_BITS-1:0]     cnt_dec;
    logic [IDX_BITS-1:0]       idx_inc;
    logic [IDX_BITS-1:0]       mag_limit;
    logic                      mag_done;
    logic [BYTE_BITS-1:0]      acc_upd;
    logic [COUNT_BITS-1:0]     hdr_cnt;

    // Take a new byte only once the previous one is used up
    assign in_stall = !empty;
    assign load     = in_valid && empty;
    assign out_free = !out_valid_reg || !out_stall;

    dvlc_bit_shifter u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_byte (in_byte),
        .ctrl      (ctrl),
        .cur_bit   (cur_bit),
        .cur_byte  (cur_byte),
        .empty     (empty)
    );

    // Magnitude datapath
    assign idx_inc   = mag_idx_reg + 1'b1;
    assign mag_limit = {1'b0, run_reg} + IDX_BITS'(MAG_EXTRA);
    assign mag_done  = (idx_inc >= mag_limit);
    assign cnt_dec   = cnt_reg - 1'b1;
    assign hdr_cnt   = {cnt_reg[COUNT_BITS-BYTE_BITS-1:0], cur_byte};

    always_comb
    begin
        acc_upd = acc_reg;
        if (mag_idx_reg < IDX_BITS'(BYTE_BITS))
        begin
            acc_upd[mag_idx_reg[ACC_POS_BITS-1:0]] = cur_bit;
        end
    end

    // Outputs of the phase machine: shifter control and sample emission
    always_comb
    begin
        ctrl        = '0;
        emit        = 1'b0;
        emit_sample = cur_reg;
        if (!empty)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    ctrl.flush = 1'b1;
                end
                PH_FIRST:
                begin
                    if (out_free)
                    begin
                        emit        = 1'b1;
                        emit_sample = cur_byte;
                        ctrl.flush  = 1'b1;
                    end
                end
                PH_SIGN, PH_RUN:
                begin
                    ctrl.step = 1'b1;
                end
                PH_MAG:
                begin
                    emit_sample = sign_reg ? (cur_reg + acc_upd) : (cur_reg - acc_upd);
                    if (!mag_done)
                    begin
                        ctrl.step = 1'b1;
                    end
                    else if (out_free)
                    begin
                        ctrl.step = 1'b1;
                        emit      = 1'b1;
                    end
                end
                default:
                begin
                    ctrl.flush = 1'b1;
                end
            endcase
        end
    end

    // Next state of the phase machine and its datapath
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        cnt_next     = cnt_reg;
        sign_next    = sign_reg;
        run_next     = run_reg;
        mag_idx_next = mag_idx_reg;
        acc_next     = acc_reg;
        cur_next     = cur_reg;
        if (!empty)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    cnt_next     = hdr_cnt;
                    hdr_idx_next = hdr_idx_reg + 1'b1;
                    if (hdr_idx_reg == HDR_LAST_IDX)
                    begin
                        phase_next = (hdr_cnt == '0) ? PH_DONE : PH_FIRST;
                    end
                end
                PH_SIGN:
                begin
                    sign_next  = cur_bit;
                    run_next   = '0;
                    phase_next = PH_RUN;
                end
                PH_RUN:
                begin
                    if (cur_bit == sign_reg)
                    begin
                        if (run_reg != RUN_MAX)
                        begin
                            run_next = run_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        mag_idx_next = '0;
                        acc_next     = '0;
                        phase_next   = PH_MAG;
                    end
                end
                PH_MAG:
                begin
                    if (ctrl.step)
                    begin
                        mag_idx_next = idx_inc;
                        acc_next     = acc_upd;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        // Count down and advance on each emitted sample
        if (emit)
        begin
            cnt_next   = cnt_dec;
            cur_next   = emit_sample;
            phase_next = (cnt_dec == '0) ? PH_DONE : PH_SIGN;
        end
    end

    // Output register: load on emit, drop after transfer
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        sample_next    = sample_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            sample_next    = emit_sample;
            last_next      = (cnt_dec == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_idx_reg   <= '0;
            cnt_reg       <= '0;
            sign_reg      <= 1'b0;
            run_reg       <= '0;
            mag_idx_reg   <= '0;
            acc_reg       <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            cnt_reg       <= cnt_next;
            sign_reg      <= sign_next;
            run_reg       <= run_next;
            mag_idx_reg   <= mag_idx_next;
            acc_reg       <= acc_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold output payload
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign last      = last_reg;

    // Never overwrite a sample that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("sample emitted over a stalled output");

    // Done is final until reset
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("left done phase");

    // Samples remain to be emitted while decoding
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FIRST || phase_reg == PH_SIGN || phase_reg == PH_RUN
         || phase_reg == PH_MAG) |-> cnt_reg != '0)
        else $error("decoding with zero count");

    // Magnitude index stays below its limit
    a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_MAG |-> mag_idx_reg < mag_limit)
        else $error("magnitude index overran");

    // A final sample always ends decoding
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        emit && (cnt_dec == '0) |=> phase_reg == PH_DONE)
        else $error("final sample did not end decoding");

endmodule

/* test/delta_vlc_byte_decoder_check.sv */
`timescale 1ns / 1ps
// Checker for the delta VLC byte decoder: predicts samples from byte transfers and compares.
module delta_vlc_byte_decoder_check #(
    parameter int RUN_COUNT_BITS = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] sample,
    input  logic       last,
    output int         fail_count,
    output int         pending
);
    import dvlc_pkg::*;

    localparam int MISMATCH_REPORTS = 10;

    typedef struct packed {
        logic [7:0] sample;
        logic       last;
    } sample_t;

    // Samples predicted but not yet seen on the output
    sample_t sample_q[$];

    // Decoder state as predicted
    phase_t                    dec_phase;
    logic [HDR_IDX_BITS-1:0]   hdr_idx;
    logic [COUNT_BITS-1:0]     samples_left;
    logic                      sign_bit;
    logic [RUN_COUNT_BITS-1:0] run_len;
    logic [RUN_COUNT_BITS:0]   mag_idx;
    logic [7:0]                mag_acc;
    logic [7:0]                running;

    // Queue the running sample, flag it when the count runs out
    function automatic void push_sample();
        samples_left = samples_left - 1'b1;
        sample_q.push_back(sample_t'{running, samples_left == '0});
        dec_phase = (samples_left == '0) ? PH_DONE : PH_SIGN;
    endfunction

    // Advance the predicted decoder over one stream byte
    function automatic void decode_byte(input logic [7:0] code);
        int   i;
        logic code_bit;
        case (dec_phase)
            PH_HEADER:
            begin
                samples_left = {samples_left[COUNT_BITS-BYTE_BITS-1:0], code};
                if (hdr_idx == HDR_LAST_IDX)
                    dec_phase = (samples_left == '0) ? PH_DONE : PH_FIRST;
                hdr_idx = hdr_idx + 1'b1;
            end
            PH_FIRST:
            begin
                running = code;
                push_sample();
            end
            PH_DONE:
            begin
            end
            default:
            begin
                // Walk the code bits MSB first, stop once the last sample is out
                for (i = BYTE_BITS - 1; i >= 0 && dec_phase != PH_DONE; i--)
                begin
                    code_bit = code[i];
                    case (dec_phase)
                        PH_SIGN:
                        begin
                            sign_bit  = code_bit;
                            run_len   = '0;
                            dec_phase = PH_RUN;
                        end
                        PH_RUN:
                        begin
                            if (code_bit == sign_bit)
                            begin
                                // Saturate the run count
                                if (run_len != '1)
                                    run_len = run_len + 1'b1;
                            end
                            else
                            begin
                                mag_idx   = '0;
                                mag_acc   = '0;
                                dec_phase = PH_MAG;
                            end
                        end
                        PH_MAG:
                        begin
                            // Only the low byte of the magnitude counts
                            if (mag_idx < BYTE_BITS)
                                mag_acc[mag_idx[ACC_POS_BITS-1:0]] = code_bit;
                            mag_idx = mag_idx + 1'b1;
                            if (mag_idx >= run_len + MAG_EXTRA)
                            begin
                                running = sign_bit ? running + mag_acc : running - mag_acc;
                                push_sample();
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase
    endfunction

    // Compare one output transfer against the oldest prediction
    function automatic void check_sample();
        sample_t want;
        if (sample_q.size() == 0)
        begin
            if (fail_count < MISMATCH_REPORTS)
                $display("%0t: unexpected sample %h last %b, none predicted",
                         $realtime, sample, last);
            fail_count++;
        end
        else
        begin
            want = sample_q.pop_front();
            if (sample !== want.sample || last !== want.last)
            begin
                if (fail_count < MISMATCH_REPORTS)
                    $display("%0t: sample %h last %b, expected sample %h last %b",
                             $realtime, sample, last, want.sample, want.last);
                fail_count++;
            end
        end
    endfunction

    // Track transfers on both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_phase    = PH_HEADER;
            hdr_idx      = '0;
            samples_left = '0;
            sign_bit     = 1'b0;
            run_len      = '0;
            mag_idx      = '0;
            mag_acc      = '0;
            running      = '0;
            sample_q.delete();
            fail_count   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                decode_byte(in_byte);
            if (out_valid && !out_stall)
                check_sample();
        end
        pending = sample_q.size();
    end

endmodule

/* test/delta_vlc_byte_decoder_test.sv */
`timescale 1ns / 1ps
// Testbench top for the delta VLC byte decoder: stream generation, flow control and verdict.
module delta_vlc_byte_decoder_test;
    import dvlc_pkg::*;

    localparam int RUN_COUNT_BITS = 6;
    localparam int RUN_MAX        = (1 << RUN_COUNT_BITS) - 1;
    localparam int CODE_BYTES     = 1545;
    localparam int TRAILING_BYTES = 24;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RESET_CYCLES   = 9;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = '0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] sample;
    logic       last;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;

    // Idle percentages per quarter of the stream
    int gap_by_quarter[4]   = '{0, 67, 0, 11};
    int stall_by_quarter[4] = '{0, 0, 67, 11};

    bit         code_bits[$];
    logic [7:0] stream_q[$];

    delta_vlc_byte_decoder #(
        .RUN_COUNT_BITS(RUN_COUNT_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample   (sample),
        .last     (last)
    );

    delta_vlc_byte_decoder_check #(
        .RUN_COUNT_BITS(RUN_COUNT_BITS)
    ) sample_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .last      (last),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the output side at random
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Append one delta code: sign, run, terminator, magnitude LSB first
    function automatic void add_delta(input bit sign, input int run, input logic [7:0] mag);
        int mag_bits;
        mag_bits = ((run > RUN_MAX) ? RUN_MAX : run) + MAG_EXTRA;
        code_bits.push_back(sign);
        repeat (run) code_bits.push_back(sign);
        code_bits.push_back(!sign);
        for (int i = 0; i < mag_bits; i++)
            code_bits.push_back((i < BYTE_BITS) ? mag[i[2:0]] : 1'($urandom_range(0, 1)));
    endfunction

    // Build header, first sample, code bytes and random trailing bytes
    task automatic build_stream();
        int          deltas;
        int          pick;
        int          run;
        logic [31:0] count;
        logic [7:0]  packed_byte;

        // Directed deltas: zero, small, full byte both ways, wide magnitude
        add_delta(1'b1, 0, 8'h00);
        add_delta(1'b0, 0, 8'h07);
        add_delta(1'b1, 5, 8'hff);
        add_delta(1'b0, 5, 8'hff);
        add_delta(1'b0, 6, 8'h80);
        add_delta(1'b1, 1, 8'h1f);
        add_delta(1'b0, 2, 8'h3a);
        deltas = 7;

        // Random deltas, mostly short runs, a few past saturation
        while (code_bits.size() < BYTE_BITS * CODE_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                run = $urandom_range(0, 3);
            else if (pick < 95)
                run = $urandom_range(4, 12);
            else if (pick < 98)
                run = $urandom_range(13, 40);
            else
                run = $urandom_range(RUN_MAX - 8, RUN_MAX + 12);
            add_delta(1'($urandom_range(0, 1)), run, 8'($urandom));
            deltas++;
        end
        while (code_bits.size() % BYTE_BITS != 0)
            code_bits.push_back(1'($urandom_range(0, 1)));

        // Pick the count: mostly ending near the stream end, else zero or huge
        pick = $urandom_range(0, 15);
        if (pick == 0)
            count = '0;
        else if (pick < 3)
            count = {1'b1, 31'($urandom)};
        else
            count = 1 + deltas - $urandom_range(0, 2);

        stream_q.push_back(count[31:24]);
        stream_q.push_back(count[23:16]);
        stream_q.push_back(count[15:8]);
        stream_q.push_back(count[7:0]);
        stream_q.push_back(8'hff);

        // Pack code bits MSB first
        for (int i = 0; i < code_bits.size(); i += BYTE_BITS)
        begin
            for (int j = 0; j < BYTE_BITS; j++)
                packed_byte[BYTE_BITS-1-j] = code_bits[i+j];
            stream_q.push_back(packed_byte);
        end

        repeat (TRAILING_BYTES) stream_q.push_back(8'($urandom));
    endtask

    // Hold reset, then feed the stream and give the verdict
    initial
    begin
        build_stream();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stream_q[i])
        begin
            gap_pct   = gap_by_quarter[i * 4 / stream_q.size()];
            stall_pct = stall_by_quarter[i * 4 / stream_q.size()];
            while ($urandom_range(0, 99) < gap_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_byte  <= stream_q[i];
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // Drain outstanding samples, then watch for strays
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
